/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hw/rtl/rq_pkg.sv */
// Package with the types, constants and opcodes of the ready queue.
package rq_pkg;
	localparam int Depth = 16;
	localparam int CntW = $clog2(Depth + 1);
	localparam int IdxW = $clog2(Depth);

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_SORTED = 3'd1,
		OP_PREPEND = 3'd2,
		OP_POP = 3'd3,
		OP_SHORTEST = 3'd4,
		OP_AGE = 3'd5
	} opcode_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [7:0] pid;
		logic [15:0] length;
		logic [15:0] score;
	} job_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] item_pid;
		logic [15:0] job_length;
		logic [15:0] prio_score;
		logic [7:0] except_pid;
		logic except_valid;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic taken_valid;
		logic [7:0] taken_pid;
		logic [15:0] taken_length;
		logic [15:0] taken_score;
		logic head_valid;
		logic [7:0] head_pid;
		logic [4:0] occupancy;
	} out_item_t;

	// Per-cycle command from the sequencer to every cell.
	typedef struct packed {
		logic hold;     // keep contents
		logic ins;      // insert new job at position ins_pos
		logic [IdxW-1:0] ins_pos;
		logic del;      // delete job at position del_pos (shift left above)
		logic [IdxW-1:0] del_pos;
		job_t new_job;
	} cell_cmd_t;

	// a strictly before b, ordered by score and then by pid
	function automatic logic orders_before(input job_t a, input job_t b);
		orders_before = (a.score != b.score) ? (a.score < b.score) : (a.pid < b.pid);
	endfunction
endpackage

/* hw/rtl/rq_cell.sv */
// One queue slot: holds a job and shifts it toward either neighbor on command.
module rq_cell (
	input  logic clk,
	input  logic [rq_pkg::IdxW-1:0] pos,
	input  rq_pkg::cell_cmd_t cmd,
	input  rq_pkg::job_t left_job,
	input  rq_pkg::job_t right_job,
	output rq_pkg::job_t job
);
	rq_pkg::job_t job_q;
	assign job = job_q;

	always_ff @(posedge clk) begin
		priority if (cmd.hold) begin
			job_q <= job_q;
		end else if (cmd.ins) begin
			if (pos == cmd.ins_pos)
				job_q <= cmd.new_job;
			else if (pos > cmd.ins_pos)
				job_q <= left_job;
		end else if (cmd.del) begin
			if (pos >= cmd.del_pos)
				job_q <= right_job;
		end
	end
endmodule

/* hw/rtl/ready_queue_fifo_sjf_aging.sv */
// Top level of the ready queue: handshake, sequencer and the row of slot cells.
//
// One input channel (in_valid/in_ready/in_data) carries one command transaction;
// one output channel (out_valid/out_ready/out_data) returns exactly one result
// transaction per command. The queue is a row of Depth slot cells; inserts and
// removals shift the row by one slot at once, while positions are found by
// a scan that visits one slot per cycle.
// Append, prepend, pop and the unused opcodes need no scan. Sorted insert scans
// the queue for its position. Remove-shortest scans all occupied slots. Aging
// rebuilds the queue by taking each job off the head and sorted-inserting it
// again into the part already rebuilt.
// One command is in flight at a time; in_ready is low while it is processed
// and while its result waits in the output register for out_ready, so a
// stalled receiver holds off the next command.
// Reset empties the queue (occupancy zero) and clears the output valid flag; slot
// contents are not cleared and never read before being written.
module ready_queue_fifo_sjf_aging (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rq_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rq_pkg::out_item_t out_data
);
	`include "assert_macros.svh"
	localparam int D = rq_pkg::Depth;
	localparam int IW = rq_pkg::IdxW;
	localparam int CW = rq_pkg::CntW;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,   // sorted-insert position scan
		S_MIN = 6'b000100,    // shortest-length scan
		S_AGE = 6'b001000,    // age: take next job from the head of the unsorted part
		S_ASCAN = 6'b010000,  // age: scan sorted part
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;
	rq_pkg::in_item_t cmd_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q;       // scan pointer
	logic [IW-1:0] best_q;      // best position so far
	logic [CW-1:0] sorted_q;    // age: length of sorted prefix
	logic [CW-1:0] left_q;      // age: jobs still to reinsert
	rq_pkg::job_t pend_q;       // age: job being reinserted
	rq_pkg::out_item_t res_q;
	logic out_valid_q;
	rq_pkg::cell_cmd_t cmd;
	rq_pkg::job_t jobs [D];
	rq_pkg::job_t scan_job;

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = res_q;
	assign scan_job = jobs[idx_q];

	genvar g;
	generate
		for (g = 0; g < D; g++) begin : g_cell
			rq_pkg::job_t lj, rj;
			if (g == 0) begin : g_l
				assign lj = cmd.new_job;
			end else begin : g_lm
				assign lj = jobs[g-1];
			end
			if (g == D - 1) begin : g_r
				assign rj = jobs[g];
			end else begin : g_rm
				assign rj = jobs[g+1];
			end
			rq_cell u_cell (
				.clk(clk), .pos(IW'(g)), .cmd(cmd),
				.left_job(lj), .right_job(rj), .job(jobs[g])
			);
		end
	endgenerate

	rq_pkg::job_t in_job, aged;
	logic accept;
	logic full;
	assign accept = in_valid && in_ready;
	assign full = count_q >= CW'(D);
	assign in_job = '{pid: in_data.item_pid, length: in_data.job_length,
		score: in_data.prio_score};
	always_comb begin
		aged = jobs[0];
		if (!(cmd_q.except_valid && jobs[0].pid == cmd_q.except_pid) && jobs[0].score != 16'd0)
			aged.score = jobs[0].score - 16'd1;
	end

	// The age pass keeps the unsorted jobs at the low end, [0, left_q), and
	// builds the sorted part above them, [left_q, left_q+sorted_q). Jobs are
	// taken from the head and inserted after the remaining unsorted jobs.
	logic [CW-1:0] base;
	logic [CW-1:0] age_end;
	assign base = left_q;
	assign age_end = CW'(left_q + sorted_q);

	// Cell command decode.
	logic scan_stop;
	assign scan_stop = (CW'(idx_q) >= count_q) || !rq_pkg::orders_before(scan_job, pend_q);
	// The first slot of the sorted part is passed unless the job orders strictly
	// before it; later slots are passed while they order strictly before the job.
	logic ascan_stop;
	assign ascan_stop = (CW'(idx_q) >= age_end) ||
		((CW'(idx_q) == base) ? rq_pkg::orders_before(pend_q, scan_job)
			: !rq_pkg::orders_before(scan_job, pend_q));

	// Shortest scan: the last compare and the removal happen in the same cycle.
	logic min_last;
	logic [IW-1:0] min_pos;
	rq_pkg::job_t min_job;
	assign min_last = (CW'(idx_q) + CW'(1)) >= count_q;
	assign min_pos = (CW'(idx_q) < count_q && scan_job.length < jobs[best_q].length) ?
		idx_q : best_q;
	assign min_job = jobs[min_pos];

	always_comb begin
		cmd = '0;
		cmd.hold = 1'b1;
		cmd.new_job = pend_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !full) begin
					if (in_data.opcode == rq_pkg::OP_APPEND) begin
						cmd.hold = 1'b0; cmd.ins = 1'b1; cmd.ins_pos = IW'(count_q);
						cmd.new_job = in_job;
					end else if (in_data.opcode == rq_pkg::OP_PREPEND) begin
						cmd.hold = 1'b0; cmd.ins = 1'b1; cmd.ins_pos = '0;
						cmd.new_job = in_job;
					end
				end
				if (accept && count_q != '0 && in_data.opcode == rq_pkg::OP_POP) begin
					cmd.hold = 1'b0; cmd.del = 1'b1; cmd.del_pos = '0;
				end
			end
			S_SCAN: if (scan_stop) begin
				cmd.hold = 1'b0; cmd.ins = 1'b1; cmd.ins_pos = idx_q;
			end
			S_MIN: if (min_last) begin
				cmd.hold = 1'b0; cmd.del = 1'b1; cmd.del_pos = min_pos;
			end
			S_AGE: if (left_q != '0) begin
				// remove the head job; it is held in pend_q
				cmd.hold = 1'b0; cmd.del = 1'b1; cmd.del_pos = '0;
			end
			S_ASCAN: if (ascan_stop) begin
				// insert at idx_q; sorted part sits above the unsorted jobs
				cmd.hold = 1'b0; cmd.ins = 1'b1; cmd.ins_pos = idx_q;
			end
			default: ;
		endcase
	end

	// What an accepted command starts: first result fields, scan start,
	// next state and the occupancy for the commands that finish at once.
	state_t idle_next;
	rq_pkg::out_item_t idle_res;
	logic [IW-1:0] idle_idx;
	logic [CW-1:0] idle_count;
	always_comb begin
		idle_res = '0;
		idle_idx = '0;
		idle_next = S_DONE;
		idle_count = count_q;
		unique case (in_data.opcode)
			rq_pkg::OP_APPEND, rq_pkg::OP_PREPEND: begin
				if (full) idle_res.status = rq_pkg::ST_FULL;
				else idle_count = count_q + CW'(1);
			end
			rq_pkg::OP_SORTED: begin
				if (full) idle_res.status = rq_pkg::ST_FULL;
				else begin
					// idx 0 stops at once when the job goes to the front
					idle_next = S_SCAN;
					if (count_q != '0 && !rq_pkg::orders_before(in_job, jobs[0]))
						idle_idx = IW'(1);
				end
			end
			rq_pkg::OP_POP, rq_pkg::OP_SHORTEST: begin
				if (count_q == '0) idle_res.status = rq_pkg::ST_EMPTY;
				else if (in_data.opcode == rq_pkg::OP_POP) begin
					idle_res.taken_valid = 1'b1;
					idle_res.taken_pid = jobs[0].pid;
					idle_res.taken_length = jobs[0].length;
					idle_res.taken_score = jobs[0].score;
					idle_count = count_q - CW'(1);
				end else begin
					idle_idx = IW'(1);
					idle_next = S_MIN;
				end
			end
			rq_pkg::OP_AGE: idle_next = S_AGE;
			default: ;
		endcase
	end

	rq_pkg::out_item_t min_res;
	rq_pkg::out_item_t done_res;
	always_comb begin
		min_res = '0;
		min_res.status = rq_pkg::ST_OK;
		min_res.taken_valid = 1'b1;
		min_res.taken_pid = min_job.pid;
		min_res.taken_length = min_job.length;
		min_res.taken_score = min_job.score;
		done_res = res_q;
		done_res.head_valid = count_q != '0;
		done_res.head_pid = (count_q != '0) ? jobs[0].pid : 8'd0;
		done_res.occupancy = 5'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			best_q <= '0;
			sorted_q <= '0;
			left_q <= '0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) begin
					cmd_q <= in_data;
					res_q <= idle_res;
					pend_q <= in_job;
					idx_q <= idle_idx;
					best_q <= '0;
					left_q <= count_q;
					sorted_q <= '0;
					count_q <= idle_count;
					state_q <= idle_next;
				end
				S_SCAN: begin
					if (count_q == '0 || idx_q == '0 || scan_stop) begin
						count_q <= count_q + CW'(1);
						state_q <= S_DONE;
					end else
						idx_q <= idx_q + IW'(1);
				end
				S_MIN: begin
					if (min_last) begin
						res_q <= min_res;
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end else begin
						best_q <= min_pos;
						idx_q <= idx_q + IW'(1);
					end
				end
				S_AGE: begin
					if (left_q == '0) state_q <= S_DONE;
					else begin
						pend_q <= aged;
						left_q <= left_q - CW'(1);
						idx_q <= IW'(left_q - CW'(1));
						state_q <= S_ASCAN;
					end
				end
				S_ASCAN: begin
					// after the head removal, unsorted jobs sit in [0,left_q),
					// sorted ones in [left_q, left_q+sorted_q)
					if (ascan_stop) begin
						sorted_q <= sorted_q + CW'(1);
						state_q <= S_AGE;
					end else
						idx_q <= idx_q + IW'(1);
				end
				S_DONE: begin
					res_q <= done_res;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_NEXT(a_one_result, clk, arst_n, accept, !in_ready, "input taken while busy")
	`ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(D), "occupancy overflow")
	`ASSERT_IMPL(a_busy_no_out, clk, arst_n, state_q != S_IDLE && state_q != S_DONE,
		!in_ready, "ready while processing")
endmodule
